### hdl/asste_pkg.sv
// constants and phase codes for the s5 sleep type extractor
`default_nettype none

package asste_pkg;

  localparam int unsigned WindowDepth = 6;
  localparam int unsigned SleepShift  = 10;

  localparam logic [7:0] NAME_PREFIX = 8'h08;
  localparam logic [7:0] ROOT_CHAR   = 8'h5C;
  localparam logic [7:0] PACKAGE_OP  = 8'h12;
  localparam logic [7:0] BYTE_PREFIX = 8'h0A;

  // "_S5_"
  localparam logic [7:0] NAME_CHAR0 = 8'h5F;
  localparam logic [7:0] NAME_CHAR1 = 8'h53;
  localparam logic [7:0] NAME_CHAR2 = 8'h35;
  localparam logic [7:0] NAME_CHAR3 = 8'h5F;

  // parse phase codes
  localparam logic [2:0] PH_SCAN    = 3'd0;
  localparam logic [2:0] PH_OPCODE  = 3'd1;
  localparam logic [2:0] PH_LEAD    = 3'd2;
  localparam logic [2:0] PH_SKIP    = 3'd3;
  localparam logic [2:0] PH_VALUE_A = 3'd4;
  localparam logic [2:0] PH_VALUE_B = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  localparam logic [2:0] SEEN_MAX = 3'd6;

endpackage

`default_nettype wire

### hdl/aml_s5_sleep_type_extractor.sv
// top level: byte-stream scanner that extracts the s5 sleep type values
`default_nettype none

// Takes one table body byte per transaction and accepts a new byte in every
// cycle: each byte updates a six-byte window and a small phase register, both
// registered. On the transaction flagged tlast one result is loaded into the
// output register (shown on the master side in the cycle after acceptance) and
// all scan state returns to its reset value for the next table. While a result
// waits, s_axis_tready follows m_axis_tready, so a byte is taken in the same
// cycle that the result leaves and the input stalls for as long as the master
// side holds off. Results carry the found flag in tuser and both sleep words
// plus the raw values in tdata.
module aml_s5_sleep_type_extractor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] table_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [15:0] sleep_word_a, [31:16] sleep_word_b,
                                           // [39:32] raw_value_a, [47:40] raw_value_b
  output logic             m_axis_tuser    // found
);
  import asste_pkg::*;

  logic [7:0] recent_q [WindowDepth];
  logic [7:0] recent_d [WindowDepth];
  logic [2:0] seen_q, seen_d;
  logic [2:0] phase_q, phase_d;
  logic [2:0] skip_q, skip_d;
  logic [7:0] value_a_q, value_a_d;
  logic [7:0] value_b_q, value_b_d;

  logic       out_valid_q;
  logic       out_found_q;
  logic [7:0] out_raw_a_q, out_raw_b_q;

  logic       in_accept;
  logic [7:0] in_byte;
  logic       name_match;
  logic       name_ok;
  logic       found_w;

  assign in_byte       = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    for (int i = 0; i < WindowDepth - 1; i++) begin
      recent_d[i] = recent_q[i+1];
    end
    recent_d[WindowDepth-1] = in_byte;
    seen_d = (seen_q < SEEN_MAX) ? seen_q + 3'd1 : seen_q;

    // window after the shift holds the name in its top four places
    name_match = (recent_q[3] == NAME_CHAR0) && (recent_q[4] == NAME_CHAR1) &&
                 (recent_q[5] == NAME_CHAR2) && (in_byte == NAME_CHAR3);
    name_ok = name_match &&
              (((seen_d >= 3'd5) && (recent_d[1] == NAME_PREFIX)) ||
               ((seen_d >= 3'd6) && (recent_d[0] == NAME_PREFIX) &&
                (recent_d[1] == ROOT_CHAR)));

    phase_d   = phase_q;
    skip_d    = skip_q;
    value_a_d = value_a_q;
    value_b_d = value_b_q;

    unique case (phase_q)
      PH_SCAN: begin
        if (name_ok) phase_d = PH_OPCODE;
      end
      PH_OPCODE: begin
        phase_d = (in_byte == PACKAGE_OP) ? PH_LEAD : PH_SCAN;
      end
      PH_LEAD: begin
        // package length bytes: lead byte count in the top two bits
        skip_d  = {1'b0, in_byte[7:6]} + 3'd1;
        phase_d = PH_SKIP;
      end
      PH_SKIP: begin
        skip_d = (skip_q != 3'd0) ? skip_q - 3'd1 : 3'd0;
        if (skip_d == 3'd0) phase_d = PH_VALUE_A;
      end
      PH_VALUE_A: begin
        // skip_q set means the byte after a byte prefix is awaited
        if (skip_q == 3'd0 && in_byte == BYTE_PREFIX) begin
          skip_d = 3'd1;
        end else begin
          skip_d    = 3'd0;
          value_a_d = in_byte;
          phase_d   = PH_VALUE_B;
        end
      end
      PH_VALUE_B: begin
        if (skip_q == 3'd0 && in_byte == BYTE_PREFIX) begin
          skip_d = 3'd1;
        end else begin
          skip_d    = 3'd0;
          value_b_d = in_byte;
          phase_d   = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    found_w = (phase_d == PH_VALUE_B) || (phase_d == PH_DONE) ||
              ((phase_d == PH_VALUE_A) && (skip_d != 3'd0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WindowDepth; i++) begin
        recent_q[i] <= 8'h00;
      end
      seen_q    <= 3'd0;
      phase_q   <= PH_SCAN;
      skip_q    <= 3'd0;
      value_a_q <= 8'h00;
      value_b_q <= 8'h00;
    end else if (in_accept) begin
      if (s_axis_tlast) begin
        for (int i = 0; i < WindowDepth; i++) begin
          recent_q[i] <= 8'h00;
        end
        seen_q    <= 3'd0;
        phase_q   <= PH_SCAN;
        skip_q    <= 3'd0;
        value_a_q <= 8'h00;
        value_b_q <= 8'h00;
      end else begin
        recent_q  <= recent_d;
        seen_q    <= seen_d;
        phase_q   <= phase_d;
        skip_q    <= skip_d;
        value_a_q <= value_a_d;
        value_b_q <= value_b_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && s_axis_tlast) begin
      out_found_q <= found_w;
      out_raw_a_q <= value_a_d;
      out_raw_b_q <= value_b_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {out_raw_b_q, out_raw_a_q,
                          out_raw_b_q[15-SleepShift:0], {SleepShift{1'b0}},
                          out_raw_a_q[15-SleepShift:0], {SleepShift{1'b0}}};

  // a byte without tlast never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !s_axis_tlast && !out_valid_q) |=> !out_valid_q)
    else $error("result appeared without a last byte");

  // a last byte presents a result and restarts the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tlast) |=> (out_valid_q && phase_q == PH_SCAN && seen_q == 3'd0))
    else $error("last byte did not deliver a result and clear the scan");

  // values are only captured once a package has been committed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_raw_a_q == 8'h00 && out_raw_b_q == 8'h00))
    else $error("nonzero value reported without a found package");

  // skip count never exceeds the longest package length encoding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q <= 3'd4)
    else $error("skip count out of range");

endmodule

`default_nettype wire
